@@ hdl/rrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rrm_pkg;
  localparam int RingDepth = 256;
  localparam int PtrW = $clog2(RingDepth);
  localparam int PatternMax = 16;
  localparam int LenW = $clog2(PatternMax + 1);
  localparam int ErrLen = 5;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    OUT_WAIT    = 2'd0,
    OUT_MATCHED = 2'd1,
    OUT_ERROR   = 2'd2,
    OUT_TIMEOUT = 2'd3
  } outcome_e;

  localparam logic [1:0] REG_PAT_LO = 2'd0;
  localparam logic [1:0] REG_PAT_HI = 2'd1;
  localparam logic [1:0] REG_PAT_LEN = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } cmd_t;

  function automatic logic [7:0] err_char(input logic [2:0] k);
    case (k)
      3'd0: err_char = 8'h45;
      3'd1: err_char = 8'h52;
      3'd2: err_char = 8'h52;
      3'd3: err_char = 8'h4F;
      3'd4: err_char = 8'h52;
      default: err_char = 8'h00;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ hdl/rrm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rrm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/rrm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rrm_front
  import rrm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] byte_i,
  output logic            q_valid_o,
  input  wire logic       q_pop_i,
  output cmd_t            q_cmd_o
);
  // Two-entry queue between the stream input and the sequencer.
  cmd_t       buf_q [2];
  logic       rd_q, wr_q, rd_d, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = buf_q[rd_q];

  always_comb begin
    wr_d = wr_q ^ push;
    rd_d = rd_q ^ (q_pop_i && q_valid_o);
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q].op <= op_i;
      buf_q[wr_q].rx_byte <= byte_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !in_valid_i) |=> cnt_q == 2'd0)
    else $error("queue filled from nothing");
endmodule
`default_nettype wire

@@ hdl/rrm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rrm_back
  import rrm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_pop_o,
  input  cmd_t             q_cmd_i,
  input  wire logic [63:0] pat_lo_i,
  input  wire logic [63:0] pat_hi_i,
  input  wire logic [4:0]  pat_len_i,
  input  wire logic [31:0] timeout_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       outcome_o,
  output logic             overflowed_o,
  output logic [7:0]       bytes_held_o
);
  // Sequencer: a tick walks start offsets s and pattern index k, one ring
  // read at a time, first for the expected pattern, then for ERROR.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_NEXT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e          st_q, st_d;
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic            ovf_q, ovf_d;
  logic [31:0]     cd_q, cd_d;
  logic [1:0]      oc_q, oc_d;
  logic            err_q, err_d;
  logic [PtrW-1:0] s_q, s_d;
  logic [LenW-1:0] k_q, k_d;
  logic            ov_q, ov_d;

  logic            we;
  logic [PtrW-1:0] raddr;
  logic [7:0]      rdata;
  logic [PtrW-1:0] held;
  logic [LenW-1:0] len;
  logic [LenW-1:0] plen;
  logic [7:0]      pch;
  logic [PtrW:0]   lim;

  rrm_ram #(.Width(8), .Depth(RingDepth)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(wp_q), .wdata_i(q_cmd_i.rx_byte),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign held = wp_q - rp_q;
  assign plen = (pat_len_i > 5'(PatternMax)) ? LenW'(PatternMax) : LenW'(pat_len_i);
  assign len = err_q ? LenW'(ErrLen) : plen;
  assign raddr = rp_q + s_q + PtrW'(k_q);
  assign lim = {1'b0, s_q} + (PtrW+1)'(len);
  always_comb begin
    if (err_q) pch = err_char(k_q[2:0]);
    else if (k_q < LenW'(8)) pch = pat_lo_i[8*k_q[2:0] +: 8];
    else pch = pat_hi_i[8*k_q[2:0] +: 8];
  end

  assign q_pop_o = (st_q == ST_IDLE) && q_valid_i && !ov_q;
  assign we = q_pop_o && (q_cmd_i.op == OP_BYTE);
  assign out_valid_o = ov_q;
  assign outcome_o = oc_q;
  assign overflowed_o = ovf_q;
  assign bytes_held_o = 8'(held);

  always_comb begin
    st_d = st_q; wp_d = wp_q; rp_d = rp_q; ovf_d = ovf_q; cd_d = cd_q;
    oc_d = oc_q; err_d = err_q; s_d = s_q; k_d = k_q;
    ov_d = ov_q && !out_ready_i;
    case (st_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          case (q_cmd_i.op)
            OP_BYTE: begin
              wp_d = wp_q + 1'b1;
              if (wp_d == rp_q) begin
                rp_d = rp_q + 1'b1;
                ovf_d = 1'b1;
              end
              ov_d = 1'b1;
            end
            OP_START: begin
              wp_d = '0; rp_d = '0; ovf_d = 1'b0; oc_d = OUT_WAIT;
              cd_d = timeout_i; ov_d = 1'b1;
            end
            OP_TICK: begin
              if (oc_q != OUT_WAIT) ov_d = 1'b1;
              else if (cd_q == '0) begin
                oc_d = OUT_TIMEOUT; ov_d = 1'b1;
              end else begin
                err_d = 1'b0; s_d = '0; k_d = '0; st_d = ST_NEXT;
              end
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      ST_NEXT: begin
        // Check whether the current start offset still fits.
        if (len == '0 || lim > (PtrW+1)'(held)) begin
          if (!err_q) begin
            err_d = 1'b1; s_d = '0; k_d = '0;
          end else begin
            cd_d = cd_q - 1'b1; st_d = ST_DONE;
          end
        end else begin
          st_d = ST_ISSUE;
        end
      end
      ST_ISSUE: st_d = ST_CMP;
      ST_CMP: begin
        if (rdata != pch) begin
          s_d = s_q + 1'b1; k_d = '0; st_d = ST_NEXT;
        end else if (k_q + 1'b1 == len) begin
          oc_d = err_q ? OUT_ERROR : OUT_MATCHED; st_d = ST_DONE;
        end else begin
          k_d = k_q + 1'b1; st_d = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (!ov_q) begin
          ov_d = 1'b1; st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; wp_q <= '0; rp_q <= '0; ovf_q <= 1'b0; cd_q <= '0;
      oc_q <= OUT_WAIT; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; wp_q <= wp_d; rp_q <= rp_d; ovf_q <= ovf_d; cd_q <= cd_d;
      oc_q <= oc_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d; s_q <= s_d; k_q <= k_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oc_q != OUT_WAIT && st_q != ST_IDLE) |-> st_q == ST_DONE)
    else $error("scan running after an outcome");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !ov_q)
    else $error("pop while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !(q_pop_o && q_cmd_i.op == OP_START)) |=> ovf_q)
    else $error("overflow flag dropped without start");
endmodule
`default_nettype wire

@@ hdl/rx_ring_response_matcher_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Content
// s_axis    in         tdata[1:0] opcode, tdata[9:2] rx_byte
// m_axis    out        tdata[1:0] outcome, [2] overflowed, [10:3] bytes_held
// cfg       in         we/index/data, registers 0..3
// A byte, start or no-op item is queued, popped by the idle sequencer, and its result registered.
// A tick scan reads the ring through the
// single read port of the ring RAM, walked by the sequencer offset by offset.
// Reset clears pointers, flags, countdown and outcome; the ring RAM is not cleared.
// A two-entry queue decouples input from the sequencer; a pending result stalls it.
module rx_ring_response_matcher_core
  import rrm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // opcode[1:0], rx_byte[9:2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // outcome[1:0], overflowed[2], bytes_held[10:3]
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  logic [63:0] pat_lo_q, pat_hi_q;
  logic [4:0]  pat_len_q;
  logic [31:0] timeout_q;
  logic        q_valid, q_pop;
  cmd_t        q_cmd;
  logic [1:0]  outcome;
  logic        ovf;
  logic [7:0]  held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0; pat_hi_q <= '0; pat_len_q <= '0; timeout_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAT_LO:  pat_lo_q <= cfg_data_i;
        REG_PAT_HI:  pat_hi_q <= cfg_data_i;
        REG_PAT_LEN: pat_len_q <= cfg_data_i[4:0];
        REG_TIMEOUT: timeout_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  rrm_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready), .op_i(s_axis_tdata[1:0]), .byte_i(s_axis_tdata[9:2]),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  rrm_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_cmd_i(q_cmd), .pat_lo_i(pat_lo_q), .pat_hi_i(pat_hi_q),
    .pat_len_i(pat_len_q), .timeout_i(timeout_q), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .outcome_o(outcome), .overflowed_o(ovf),
    .bytes_held_o(held)
  );

  assign m_axis_tdata = {5'd0, held, ovf, outcome};
endmodule
`default_nettype wire

@@ tb/sv/tb_rx_ring_response_matcher_core.sv @@
`timescale 1ns / 1ps
module tb_rx_ring_response_matcher_core;
  import rrm_pkg::*;

  typedef struct packed {
    outcome_e   outcome;
    logic       overflowed;
    logic [7:0] bytes_held;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  rx_ring_response_matcher_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),   // opcode[1:0], rx_byte[9:2]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),   // outcome[1:0], overflowed[2], bytes_held[10:3]
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block's state.
  logic [7:0]  ring_mem [RingDepth];
  logic [PtrW-1:0] wr_ptr = '0, rd_ptr = '0;
  logic        ovf_flag = 1'b0;
  logic [31:0] ticks_left = '0;
  outcome_e    verdict = OUT_WAIT;
  logic [63:0] pat_lo = '0, pat_hi = '0;
  logic [4:0]  pat_len = '0;
  logic [31:0] timeout_cfg = '0;

  cmd_t    cmd_q [$];
  status_t status_q [$];
  int      errors = 0;
  int      cycles = 0;
  int      idle_pct_tx = 0, idle_pct_rx = 0;
  int      hold_rx = 0;

  function automatic bit ring_has(input logic [7:0] pat [PatternMax], input int len);
    int held, s, k;
    bit hit;
    logic [PtrW-1:0] diff;
    diff = wr_ptr - rd_ptr;
    held = int'(diff);
    if (len == 0 || len > held) return 0;
    for (s = 0; s + len <= held; s++) begin
      hit = 1;
      for (k = 0; k < len; k++)
        if (ring_mem[(int'(rd_ptr) + s + k) % RingDepth] !== pat[k]) hit = 0;
      if (hit) return 1;
    end
    return 0;
  endfunction

  function automatic status_t next_status(input cmd_t c);
    logic [7:0] pat [PatternMax];
    logic [7:0] err [PatternMax];
    int len, i;
    status_t r;
    case (opcode_e'(c.op))
      OP_BYTE: begin
        if (wr_ptr + 1'b1 == rd_ptr) begin
          rd_ptr = rd_ptr + 1'b1;
          ovf_flag = 1'b1;
        end
        ring_mem[wr_ptr] = c.rx_byte;
        wr_ptr = wr_ptr + 1'b1;
      end
      OP_START: begin
        wr_ptr = '0;
        rd_ptr = '0;
        ovf_flag = 1'b0;
        verdict = OUT_WAIT;
        ticks_left = timeout_cfg;
      end
      OP_TICK: if (verdict == OUT_WAIT) begin
        len = (pat_len > PatternMax) ? PatternMax : int'(pat_len);
        for (i = 0; i < PatternMax; i++) begin
          pat[i] = (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
          err[i] = 8'h00;
        end
        err[0] = "E"; err[1] = "R"; err[2] = "R"; err[3] = "O"; err[4] = "R";
        if (ticks_left == 0) verdict = OUT_TIMEOUT;
        else if (ring_has(pat, len)) verdict = OUT_MATCHED;
        else if (ring_has(err, ErrLen)) verdict = OUT_ERROR;
        else ticks_left = ticks_left - 1;
      end
      default: ;
    endcase
    r.outcome = verdict;
    r.overflowed = ovf_flag;
    r.bytes_held = 8'(wr_ptr - rd_ptr);
    return r;
  endfunction

  task automatic report(input string what, input status_t got, input status_t want);
    $display("mismatch %s: got %0d/%0d/%0d want %0d/%0d/%0d", what, got.outcome,
             got.overflowed, got.bytes_held, want.outcome, want.overflowed,
             want.bytes_held);
    errors++;
  endtask

  // Driver.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (!s_axis_tvalid || s_axis_tready) begin
      if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct_tx) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, cmd_q[0].rx_byte, cmd_q[0].op};
        status_q.push_back(next_status(cmd_q.pop_front()));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver readiness.
  always @(posedge clk_i) begin
    if (hold_rx > 0) begin
      hold_rx <= hold_rx - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct_rx);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    status_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.outcome = outcome_e'(m_axis_tdata[1:0]);
      got.overflowed = m_axis_tdata[2];
      got.bytes_held = m_axis_tdata[10:3];
      if (status_q.size() == 0) begin
        report("unexpected beat", got, got);
      end else begin
        want = status_q.pop_front();
        if (got.outcome !== want.outcome) report("outcome", got, want);
        if (got.overflowed !== want.overflowed) report("overflowed", got, want);
        if (got.bytes_held !== want.bytes_held) report("bytes_held", got, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 10_000_000) begin
      $display("rx_ring_response_matcher_core test failed");
      $finish;
    end
  end

  task automatic push(input opcode_e op, input logic [7:0] b);
    cmd_t c;
    c.op = op;
    c.rx_byte = b;
    cmd_q.push_back(c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push(OP_BYTE, s[i]);
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || status_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    // Let the block settle before the next register write.
    repeat (20000) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PAT_LO:  pat_lo = val;
      REG_PAT_HI:  pat_hi = val;
      REG_PAT_LEN: pat_len = val[4:0];
      default:     timeout_cfg = val[31:0];
    endcase
  endtask

  // Writes a pattern of the given length, random or fixed content.
  task automatic set_pattern(input logic [127:0] chars, input logic [4:0] len);
    write_reg(REG_PAT_LO, chars[63:0]);
    write_reg(REG_PAT_HI, chars[127:64]);
    write_reg(REG_PAT_LEN, {59'd0, len});
  endtask

  // A run: start, some noise, maybe the pattern or ERROR, ticks in between and at the end.
  task automatic random_run(input int len);
    int n, i, pick;
    logic [7:0] b;
    push(OP_START, 8'h00);
    n = $urandom_range(30, 0);
    if ($urandom_range(9) == 0) n = $urandom_range(300, 250);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(19);
      if (pick == 0) push(OP_TICK, 8'h00);
      else if (pick == 1) push(opcode_e'(OP_NONE), 8'($urandom));
      else begin
        b = (pick < 10 && len > 0) ? (i < 8 ? pat_lo[8*(i%8) +: 8] : pat_hi[8*(i%8) +: 8])
                                   : 8'($urandom);
        push(OP_BYTE, b);
      end
    end
    pick = $urandom_range(3);
    if (pick == 0) begin
      for (i = 0; i < len && i < PatternMax; i++)
        push(OP_BYTE, i < 8 ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8]);
    end else if (pick == 1) begin
      push_text("ERROR");
    end
    for (i = 0; i < $urandom_range(4, 1); i++) push(OP_TICK, 8'h00);
  endtask

  initial begin
    int done_items, phase;
    logic [127:0] chars;
    logic [4:0] len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick before any start, unused opcode, extremes.
    push(OP_TICK, 8'h00);
    push(opcode_e'(OP_NONE), 8'hFF);
    drain();
    set_pattern({120'd0, 8'h00}, 5'd1);
    write_reg(REG_TIMEOUT, 64'd3);
    push(OP_START, 8'hFF);
    push(OP_TICK, 8'h00);
    push(OP_BYTE, 8'hFF);
    push(OP_BYTE, 8'h00);
    push(OP_TICK, 8'h00);
    push(OP_TICK, 8'h00);
    push(OP_BYTE, 8'hAA);
    drain();
    set_pattern({128{1'b1}}, 5'd31);
    push(OP_START, 8'h00);
    push_text("xERROR");
    push(OP_TICK, 8'h00);
    push(OP_START, 8'h00);
    push(OP_TICK, 8'h00);
    push(OP_TICK, 8'h00);
    push(OP_TICK, 8'h00);
    push(OP_TICK, 8'h00);
    push(OP_TICK, 8'h00);
    drain();
    write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
    set_pattern({128{1'b1}}, 5'd16);
    push(OP_START, 8'h00);
    for (int i = 0; i < 16; i++) push(OP_BYTE, 8'hFF);
    push(OP_TICK, 8'h00);
    drain();

    // Overflow with the receiver held off so the input side stalls.
    hold_rx = 3000;
    set_pattern({128{1'b1}}, 5'd0);
    push(OP_START, 8'h00);
    for (int i = 0; i < 270; i++) push(OP_BYTE, 8'($urandom));
    push(OP_TICK, 8'h00);
    drain();

    done_items = 0;
    phase = 0;
    while (done_items < 250 || phase < 4) begin
      case (phase % 4)
        0: begin idle_pct_tx = 0;  idle_pct_rx = 0;  end
        1: begin idle_pct_tx = 68; idle_pct_rx = 0;  end
        2: begin idle_pct_tx = 0;  idle_pct_rx = 68; end
        default: begin idle_pct_tx = 14; idle_pct_rx = 14; end
      endcase
      chars = {$urandom, $urandom, $urandom, $urandom};
      len = 5'($urandom_range(PatternMax, 0));
      if ($urandom_range(7) == 0) len = 5'($urandom_range(31, 17));
      set_pattern(chars, len);
      write_reg(REG_TIMEOUT, $urandom_range(3) == 0 ? 64'($urandom)
                                                    : 64'($urandom_range(6)));
      for (int r = 0; r < 2; r++) random_run(len > PatternMax ? PatternMax : int'(len));
      done_items += cmd_q.size();
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("rx_ring_response_matcher_core test passed");
    end else begin
      $display("rx_ring_response_matcher_core test failed");
    end
    $finish;
  end
endmodule

@@ rx_ring_response_matcher_core.f @@
hdl/rrm_pkg.sv
hdl/rrm_ram.sv
hdl/rrm_front.sv
hdl/rrm_back.sv
hdl/rx_ring_response_matcher_core.sv
tb/sv/tb_rx_ring_response_matcher_core.sv
